// ===== sv/signed_int_to_decimal_ascii_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text core
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SIDAC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SIDAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/sidac_pkg.sv =====
// ----------------------------------------------------------------------------
// sidac_pkg
// Types and constants shared by the decimal text core and its digit cells.
// ----------------------------------------------------------------------------
package sidac_pkg;

	// Width of one output character code.
	localparam int unsigned CHAR_W = 6;

	// ASCII '0' and '-' truncated to the character code width.
	localparam logic [CHAR_W-1:0] DIGIT_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] MINUS_SIGN = 6'd45;

	// Threshold and bias of the add-3 correction in a BCD digit.
	localparam logic [3:0] BCD_LIMIT = 4'd5;
	localparam logic [3:0] BCD_BIAS  = 4'd3;

	// Operation applied to every digit cell in one cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_mode_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_SIGN,
		ST_EMIT
	} state_t;

endpackage

// ===== sv/sidac_cell.sv =====
// ----------------------------------------------------------------------------
// sidac_cell
// One BCD digit of the conversion chain: add-3 and shift during conversion,
// digit hand-over toward the top of the chain during output.
// ----------------------------------------------------------------------------
module sidac_cell
	import sidac_pkg::*;
(
	input  logic       clk,
	input  cell_mode_t mode,
	input  logic       bit_in,
	input  logic [3:0] digit_in,
	output logic       bit_out,
	output logic [3:0] digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// A digit of five or more gets three added so that the following doubling
	// carries correctly into the next decade.
	always_comb begin
		adj = (digit_q >= BCD_LIMIT) ? (digit_q + BCD_BIAS) : digit_q;
	end

	assign bit_out = adj[3];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		unique case (mode)
			CELL_HOLD:   digit_q <= digit_q;
			CELL_CLEAR:  digit_q <= 4'd0;
			CELL_DABBLE: digit_q <= {adj[2:0], bit_in};
			CELL_SHIFT:  digit_q <= digit_in;
			default:     digit_q <= digit_q;
		endcase
	end

endmodule

// ===== sv/signed_int_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts one signed integer into its decimal ASCII text, most significant
// character first, with a leading minus sign for negative values.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------
// input    | in        | start, busy        | value
// result   | out       | strobe (no stall)  | char_code, last_char
//
// One word is taken at a clock edge with start high and busy low. The block
// then runs the serial double-dabble loop through the chain of BCD digit
// cells, one input bit per cycle, then strips leading zeros and outputs the
// digits, one cell per cycle, with a minus sign before them for a negative
// value. It takes no new word until the last character has been sent.
// Reset clears the sequencer and the output strobe; the receiver cannot stall,
// so every character appears on the result ports for exactly one cycle.
//
module signed_int_to_decimal_ascii_core
	import sidac_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 32
)(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   strobe,
	output logic [CHAR_W-1:0]      char_code,
	output logic                   last_char
);

	// Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1). The factor
	// 1233/4096 approximates log10(2) closely enough over the supported widths.
	localparam int unsigned NUM_DIGITS = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
	localparam int unsigned BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	state_t                 state_q, state_d;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   dig_cnt_q;
	logic                   accept;

	cell_mode_t             cell_mode;
	logic [NUM_DIGITS-1:0]  bit_link;
	logic [3:0]             digit [NUM_DIGITS];
	logic [3:0]             top_digit;

	logic                   strobe_d;
	logic [CHAR_W-1:0]      char_code_d;
	logic                   last_char_d;

	logic                   strobe_q;
	logic [CHAR_W-1:0]      char_code_q;
	logic                   last_char_q;

	assign accept    = start && (state_q == ST_IDLE);
	assign top_digit = digit[NUM_DIGITS-1];

	// The chain of digit cells. Cell zero is the least significant decade and
	// takes the next magnitude bit; during output each cell hands its digit up
	// so that the most significant digit always sits in the top cell. The
	// carry out of the top cell stays clear for every magnitude in range.
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		logic       cell_bit_in;
		logic [3:0] cell_digit_in;

		if (i == 0) begin : g_first
			assign cell_bit_in   = mag_q[VALUE_WIDTH-1];
			assign cell_digit_in = 4'd0;
		end else begin : g_rest
			assign cell_bit_in   = bit_link[i-1];
			assign cell_digit_in = digit[i-1];
		end

		sidac_cell u_cell (
			.clk      (clk),
			.mode     (cell_mode),
			.bit_in   (cell_bit_in),
			.digit_in (cell_digit_in),
			.bit_out  (bit_link[i]),
			.digit    (digit[i])
		);
	end

	// Next state. Conversion runs once per magnitude bit; trimming drops
	// leading zeros but always keeps the last digit, so zero prints as '0'.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (bit_cnt_q == BIT_CNT_W'(1)) begin
					state_d = ST_TRIM;
				end
			end
			ST_TRIM: begin
				if (!((top_digit == 4'd0) && (dig_cnt_q != DIG_CNT_W'(1)))) begin
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (dig_cnt_q == DIG_CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: the cell operation and the next character.
	always_comb begin
		cell_mode   = CELL_HOLD;
		strobe_d    = 1'b0;
		char_code_d = DIGIT_ZERO;
		last_char_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cell_mode = CELL_CLEAR;
				end
			end
			ST_CONV: begin
				cell_mode = CELL_DABBLE;
			end
			ST_TRIM: begin
				if ((top_digit == 4'd0) && (dig_cnt_q != DIG_CNT_W'(1))) begin
					cell_mode = CELL_SHIFT;
				end
			end
			ST_SIGN: begin
				strobe_d    = 1'b1;
				char_code_d = MINUS_SIGN;
			end
			ST_EMIT: begin
				cell_mode   = CELL_SHIFT;
				strobe_d    = 1'b1;
				char_code_d = DIGIT_ZERO + {{(CHAR_W - 4){1'b0}}, top_digit};
				last_char_d = (dig_cnt_q == DIG_CNT_W'(1));
			end
			default: begin
				cell_mode = CELL_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
		end
	end

	// Datapath and counters. The magnitude is formed in VALUE_WIDTH unsigned
	// bits, so the most negative value yields 2^(VALUE_WIDTH-1) exactly.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q     <= value[VALUE_WIDTH-1];
			mag_q     <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
			bit_cnt_q <= BIT_CNT_W'(VALUE_WIDTH);
			dig_cnt_q <= DIG_CNT_W'(NUM_DIGITS);
		end else begin
			if (state_q == ST_CONV) begin
				mag_q     <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
			if (cell_mode == CELL_SHIFT) begin
				dig_cnt_q <= dig_cnt_q - 1'b1;
			end
		end
		char_code_q <= char_code_d;
		last_char_q <= last_char_d;
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign char_code = char_code_q;
	assign last_char = last_char_q;

endmodule

// ===== sv/sidac_chk.sv =====
// ----------------------------------------------------------------------------
// sidac_chk
// Port-level checks on the decimal text core, bound to its top level.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_core_assert.svh"

module sidac_chk
	import sidac_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              strobe,
	input logic [CHAR_W-1:0] char_code,
	input logic              last_char
);

	// An accepted word keeps the block busy in the following cycle.
	`SIDAC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")

	// Characters of one number come in consecutive cycles up to the last one.
	`SIDAC_ASSERT_NEXT(a_run_contiguous, strobe && !last_char, strobe, "gap inside a number's text")

	// A number's text ends with a gap before the next character.
	`SIDAC_ASSERT_NEXT(a_run_ends, strobe && last_char, !strobe, "character directly after last")

	// Only a minus sign or a decimal digit is ever sent.
	`SIDAC_ASSERT_NOW(a_char_legal, strobe,
		char_code == MINUS_SIGN || (char_code >= DIGIT_ZERO && char_code <= 6'd57),
		"illegal character code")

	// A minus sign is never the final character.
	`SIDAC_ASSERT_NOW(a_sign_not_last, strobe && char_code == MINUS_SIGN, !last_char,
		"minus sign marked as last character")

endmodule

bind signed_int_to_decimal_ascii_core sidac_chk u_sidac_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.char_code (char_code),
	.last_char (last_char)
);
